// File: hw/rtl/rwaq_pkg.sv
package rwaq_pkg;

  // requester field width on the channel
  localparam int unsigned REQ_ID_W = 8;

  // operation codes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_ADMIT   = 1'b1;

  // request kinds
  localparam logic KIND_READER = 1'b0;
  localparam logic KIND_WRITER = 1'b1;

  // head kind report
  localparam logic [1:0] HEAD_EMPTY  = 2'd0;
  localparam logic [1:0] HEAD_READER = 2'd1;
  localparam logic [1:0] HEAD_WRITER = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SHIFT_WR,
    ST_DONE
  } state_e;

  // read address offset from the walk index
  typedef enum logic [1:0] {
    OFF_0,
    OFF_1,
    OFF_2
  } rd_off_e;

  typedef struct packed {
    logic    load;
    logic    enq;
    logic    rd_en;
    rd_off_e rd_off;
    logic    idx_inc;
    logic    shift_wr;
    logic    dec_occ;
    logic    set_grant;
    logic    capture;
  } cmd_t;

  typedef struct packed {
    logic is_enq;
    logic is_writer_op;
    logic empty;
    logic rd_match;
    logic rd_writer;
    logic next_in;
    logic next2_in;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/rwaq_req_if.sv
interface rwaq_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic       kind;
  logic [7:0] requester;

  modport source (output valid, output op, output kind, output requester, input ready);
  modport sink   (input valid, input op, input kind, input requester, output ready);
endinterface

// File: hw/rtl/rwaq_rsp_if.sv
interface rwaq_rsp_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic       dropped;
  logic [1:0] head_kind;

  modport source (output valid, output granted, output dropped, output head_kind, input ready);
  modport sink   (input valid, input granted, input dropped, input head_kind, output ready);
endinterface

// File: hw/rtl/reader_writer_admission_queue.sv
// channel  dir  handshake        word
// req_i    in   valid / ready    op, kind, requester
// rsp_o    out  valid / ready    granted, dropped, head_kind
//
// one item at a time; an enqueue, or an admit on an empty queue, goes straight to the result
// any other admit walks s entries from the head and moves m entries up behind the removed one;
// s + m never exceeds the fill count
// reset clears the fill count and the result valid flag; the entry ram is not cleared
// input is taken again as soon as the last result sits in the output register

module reader_writer_admission_queue
  import rwaq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwaq_req_if.sink   req_i,
  rwaq_rsp_if.source rsp_o
);

  // commands from the sequencer, flags back from the datapath
  cmd_t cmd;
  sts_t sts;

  rwaq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry ram, fill count, walk index and the result register
  rwaq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (req_i.op),
    .kind_i      (req_i.kind),
    .requester_i (req_i.requester),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .granted_o   (rsp_o.granted),
    .dropped_o   (rsp_o.dropped),
    .head_kind_o (rsp_o.head_kind)
  );

endmodule

// File: hw/rtl/rwaq_ram.sv
module rwaq_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/rwaq_dp.sv
module rwaq_dp
  import rwaq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                op_i,
  input  logic                kind_i,
  input  logic [REQ_ID_W-1:0] requester_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                granted_o,
  output logic                dropped_o,
  output logic [1:0]          head_kind_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = ID_WIDTH + 1;

  logic                     op_q, kind_q;
  logic [ID_WIDTH-1:0]      id_q;
  logic [ID_WIDTH+REQ_ID_W-1:0] id_ext;
  logic [AW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            occ_q, occ_d;
  logic                     head_writer_q, head_writer_d;
  logic                     grant_q, grant_d, drop_q, drop_d;
  logic                     out_valid_q, out_valid_d;
  logic                     res_grant_q, res_drop_q;
  logic [1:0]               res_head_q, head_code;
  logic [CW:0]              idx_ext, occ_ext, rd_sum;
  logic                     full;
  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [EW-1:0]            wr_data, rd_data;

  assign id_ext  = {{ID_WIDTH{1'b0}}, requester_i};
  assign idx_ext = (CW + 1)'(idx_q);
  assign occ_ext = (CW + 1)'(occ_q);
  assign full    = (occ_q == CW'(QUEUE_DEPTH));

  always_comb begin
    unique case (cmd_i.rd_off)
      OFF_0:   rd_sum = idx_ext;
      OFF_1:   rd_sum = idx_ext + (CW + 1)'(1);
      OFF_2:   rd_sum = idx_ext + (CW + 1)'(2);
      default: rd_sum = idx_ext;
    endcase
  end
  assign rd_addr = rd_sum[AW-1:0];
  assign rd_en   = cmd_i.rd_en;

  // write port: append at the tail or move an entry one place up
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = rd_data;
    if (cmd_i.enq && !full) begin
      wr_en   = 1'b1;
      wr_addr = occ_q[AW-1:0];
      wr_data = {kind_q, id_q};
    end else if (cmd_i.shift_wr) begin
      wr_en = 1'b1;
    end
  end

  rwaq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    idx_d         = idx_q;
    occ_d         = occ_q;
    head_writer_d = head_writer_q;
    grant_d       = grant_q;
    drop_d        = drop_q;
    if (cmd_i.load) begin
      idx_d   = '0;
      grant_d = 1'b0;
      drop_d  = 1'b0;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
    if (cmd_i.enq) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        occ_d = occ_q + CW'(1);
      end
    end
    if (wr_en && (wr_addr == '0)) begin
      head_writer_d = wr_data[EW-1];
    end
    if (cmd_i.dec_occ) begin
      occ_d = occ_q - CW'(1);
    end
    if (cmd_i.set_grant) begin
      grant_d = 1'b1;
    end
  end

  assign head_code = (occ_q == '0) ? HEAD_EMPTY : (head_writer_q ? HEAD_WRITER : HEAD_READER);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_writer_q <= head_writer_d;
    grant_q       <= grant_d;
    drop_q        <= drop_d;
    if (cmd_i.load) begin
      op_q   <= op_i;
      kind_q <= kind_i;
      id_q   <= id_ext[ID_WIDTH-1:0];
    end
    if (cmd_i.capture) begin
      res_grant_q <= grant_q;
      res_drop_q  <= drop_q;
      res_head_q  <= head_code;
    end
  end

  assign sts_o.is_enq       = (op_q == OP_ENQUEUE);
  assign sts_o.is_writer_op = (kind_q == KIND_WRITER);
  assign sts_o.empty        = (occ_q == '0);
  assign sts_o.rd_match     = (rd_data[ID_WIDTH-1:0] == id_q);
  assign sts_o.rd_writer    = (rd_data[EW-1] == KIND_WRITER);
  assign sts_o.next_in      = ((idx_ext + (CW + 1)'(1)) < occ_ext);
  assign sts_o.next2_in     = ((idx_ext + (CW + 1)'(2)) < occ_ext);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign granted_o   = res_grant_q;
  assign dropped_o   = res_drop_q;
  assign head_kind_o = res_head_q;

endmodule

// File: hw/rtl/rwaq_ctrl.sv
module rwaq_ctrl
  import rwaq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ENQ;
        end
      end
      ST_ENQ: begin
        if (sts_i.is_enq) begin
          state_d = ST_DONE;
        end else if (sts_i.empty) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        priority if (sts_i.is_writer_op) begin
          state_d = (sts_i.rd_match && sts_i.next_in) ? ST_SHIFT_WR : ST_DONE;
        end else if (sts_i.rd_writer) begin
          state_d = ST_DONE;
        end else if (sts_i.rd_match) begin
          state_d = sts_i.next_in ? ST_SHIFT_WR : ST_DONE;
        end else begin
          state_d = sts_i.next_in ? ST_SCAN_CHK : ST_DONE;
        end
      end
      ST_SHIFT_WR: begin
        if (!sts_i.next2_in) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.rd_off = OFF_0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_ENQ: begin
        cmd_o.enq = sts_i.is_enq;
      end
      ST_SCAN_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_SCAN_CHK: begin
        priority if (sts_i.is_writer_op) begin
          if (sts_i.rd_match) begin
            cmd_o.set_grant = 1'b1;
            cmd_o.rd_en     = sts_i.next_in;
            cmd_o.rd_off    = OFF_1;
            cmd_o.dec_occ   = !sts_i.next_in;
          end
        end else if (sts_i.rd_writer) begin
          cmd_o.set_grant = 1'b0;
        end else if (sts_i.rd_match) begin
          cmd_o.set_grant = 1'b1;
          cmd_o.rd_en     = sts_i.next_in;
          cmd_o.rd_off    = OFF_1;
          cmd_o.dec_occ   = !sts_i.next_in;
        end else begin
          cmd_o.rd_en   = sts_i.next_in;
          cmd_o.rd_off  = OFF_1;
          cmd_o.idx_inc = sts_i.next_in;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        cmd_o.rd_en    = sts_i.next2_in;
        cmd_o.rd_off   = OFF_2;
        cmd_o.dec_occ  = !sts_i.next2_in;
      end
      ST_DONE: begin
        cmd_o.capture = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule
